// ===== src/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, operation codes and constants of the bit-level i2c master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned BIT_W  = 4;

  // operation codes, also the command codes of the request channel
  localparam logic [CMD_W-1:0] OP_IDLE  = 3'd0;
  localparam logic [CMD_W-1:0] OP_START = 3'd1;
  localparam logic [CMD_W-1:0] OP_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] OP_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] OP_READ  = 3'd4;
  localparam logic [CMD_W-1:0] OP_WAIT  = 3'd5;

  // reset value of the ack timeout register
  localparam logic [BYTE_W-1:0] ACK_LIMIT_RESET = 8'd250;

  // bits per byte on the bus
  localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

  // depth of the queue between front and engine
  localparam int unsigned QUEUE_DEPTH = 2;

  // classified request as it sits in the queue
  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_level;
  } q_entry_t;

  // queue handshake toward the engine
  typedef struct packed {
    logic valid;
  } q_status_t;

  // one result as held in the output register
  typedef struct packed {
    logic              scl_level;
    logic              sda_release;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_error;
  } res_t;

endpackage

// ===== src/i2cm_ifs.sv =====
// ----------------------------------------------------------------------------
// i2cm channel interfaces
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
  import i2cm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] tx_byte;
  logic              send_ack;
  logic              sda_level;
  modport source (output valid, command, tx_byte, send_ack, sda_level, input ready);
  modport sink   (input valid, command, tx_byte, send_ack, sda_level, output ready);
endinterface

interface i2cm_res_if;
  import i2cm_pkg::*;
  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_release;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rx_byte;
  logic              ack_error;
  modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                  ack_error, input ready);
  modport sink   (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                  ack_error, output ready);
endinterface

interface i2cm_cfg_if;
  import i2cm_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts requests, classifies the command code and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front #(
  parameter int unsigned Depth = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  i2cm_cmd_if.sink            cmd_i,
  output i2cm_pkg::q_status_t q_status_o,
  input  logic                q_pop_i,
  output i2cm_pkg::q_entry_t  q_entry_o
);
  import i2cm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  q_entry_t        mem_q [Depth];
  q_entry_t        entry_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  // classify: unused command codes behave as tick only
  always_comb begin
    entry_d.tx_byte   = cmd_i.tx_byte;
    entry_d.send_ack  = cmd_i.send_ack;
    entry_d.sda_level = cmd_i.sda_level;
    if (cmd_i.command >= OP_START && cmd_i.command <= OP_WAIT) begin
      entry_d.op = cmd_i.command;
    end else begin
      entry_d.op = OP_IDLE;
    end
  end

  // queue handshake
  assign cmd_i.ready      = (count_q != Full);
  assign push             = cmd_i.valid && cmd_i.ready;
  assign q_status_o.valid = (count_q != '0);
  assign pop              = q_pop_i && q_status_o.valid;
  assign q_entry_o        = mem_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_d;
    end
  end

endmodule

// ===== src/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: runs one phase per queued tick and registers the result.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  i2cm_pkg::q_status_t        q_status_i,
  output logic                       q_pop_o,
  input  i2cm_pkg::q_entry_t         q_entry_i,
  input  logic [i2cm_pkg::BYTE_W-1:0] limit_i,
  i2cm_res_if.source                 res_o
);
  import i2cm_pkg::*;

  logic [CMD_W-1:0]   op_q, op_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [BYTE_W-1:0]  shift_q, shift_d;
  logic [BYTE_W-1:0]  tmo_q, tmo_d;
  logic               ack_q, ack_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               err_q, err_d;
  logic [BYTE_W-1:0]  rx_q, rx_d;
  logic               done;
  logic               out_valid_q, out_valid_d;
  res_t               out_q, out_d;

  // take a tick when the result register is free or being drained
  assign q_pop_o = q_status_i.valid && (!out_valid_q || res_o.ready);

  // phase sequencer
  always_comb begin
    op_d    = op_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    tmo_d   = tmo_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    err_d   = err_q;
    rx_d    = rx_q;
    done    = 1'b0;

    // launch a new command when idle
    if (op_q == OP_IDLE && q_entry_i.op != OP_IDLE) begin
      op_d    = q_entry_i.op;
      phase_d = '0;
      bit_d   = '0;
      if (q_entry_i.op == OP_WRITE) begin
        shift_d = q_entry_i.tx_byte;
      end
      if (q_entry_i.op == OP_READ) begin
        shift_d = '0;
        ack_d   = q_entry_i.send_ack;
      end
      if (q_entry_i.op == OP_WAIT) begin
        tmo_d = '0;
        err_d = 1'b0;
      end
    end

    case (op_d)
      OP_IDLE: begin
      end
      OP_START: begin
        if (phase_d == 3'd0) begin
          scl_d = 1'b1; sda_d = 1'b1; phase_d = 3'd1;
        end else if (phase_d == 3'd1) begin
          sda_d = 1'b0; phase_d = 3'd2;
        end else begin
          scl_d = 1'b0; done = 1'b1;
        end
      end
      OP_STOP: begin
        if (phase_d == 3'd0) begin
          scl_d = 1'b0; sda_d = 1'b0; phase_d = 3'd1;
        end else if (phase_d == 3'd1) begin
          scl_d = 1'b1; phase_d = 3'd2;
        end else begin
          sda_d = 1'b1; done = 1'b1;
        end
      end
      OP_WRITE: begin
        if (phase_d == 3'd0) begin
          scl_d   = 1'b0;
          sda_d   = shift_d[BYTE_W-1];
          shift_d = {shift_d[BYTE_W-2:0], 1'b0};
          phase_d = 3'd1;
        end else if (phase_d == 3'd1) begin
          scl_d   = 1'b1;
          bit_d   = bit_d + 1'b1;
          phase_d = (bit_d >= BITS_PER_BYTE) ? 3'd2 : 3'd0;
        end else begin
          scl_d = 1'b0; done = 1'b1;
        end
      end
      OP_READ: begin
        case (phase_d)
          3'd0: begin
            scl_d = 1'b0; sda_d = 1'b1; phase_d = 3'd1;
          end
          3'd1: begin
            scl_d = 1'b1; phase_d = 3'd2;
          end
          3'd2: begin
            shift_d = {shift_d[BYTE_W-2:0], q_entry_i.sda_level};
            bit_d   = bit_d + 1'b1;
            phase_d = (bit_d >= BITS_PER_BYTE) ? 3'd3 : 3'd0;
          end
          3'd3: begin
            scl_d = 1'b0; sda_d = !ack_d; phase_d = 3'd4;
          end
          3'd4: begin
            scl_d = 1'b1; phase_d = 3'd5;
          end
          default: begin
            scl_d = 1'b0; rx_d = shift_d; done = 1'b1;
          end
        endcase
      end
      OP_WAIT: begin
        if (phase_d == 3'd0) begin
          sda_d = 1'b1; phase_d = 3'd1;
        end else if (phase_d == 3'd1) begin
          scl_d = 1'b1; phase_d = 3'd2;
        end else if (!q_entry_i.sda_level) begin
          scl_d = 1'b0; done = 1'b1;
        end else if (tmo_d >= limit_i) begin
          // timeout: fall into the stop sequence
          err_d   = 1'b1;
          op_d    = OP_STOP;
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          phase_d = 3'd1;
        end else begin
          tmo_d = tmo_d + 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase

    if (done) begin
      op_d    = OP_IDLE;
      phase_d = '0;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_IDLE;
      phase_q <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      tmo_q   <= '0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      err_q   <= 1'b0;
      rx_q    <= '0;
    end else if (q_pop_o) begin
      op_q    <= op_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      tmo_q   <= tmo_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      err_q   <= err_d;
      rx_q    <= rx_d;
    end
  end

  // result register
  always_comb begin
    out_d.scl_level   = scl_d;
    out_d.sda_release = sda_d;
    out_d.busy_res    = (op_d != OP_IDLE);
    out_d.done_res    = done;
    out_d.rx_byte     = rx_d;
    out_d.ack_error   = err_d;
    out_valid_d       = q_pop_o || (out_valid_q && !res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.scl_level   = out_q.scl_level;
  assign res_o.sda_release = out_q.sda_release;
  assign res_o.busy_res    = out_q.busy_res;
  assign res_o.done_res    = out_q.done_res;
  assign res_o.rx_byte     = out_q.rx_byte;
  assign res_o.ack_error   = out_q.ack_error;

endmodule

// ===== src/i2c_bit_level_master.sv =====
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Bit-level i2c master: one bus timing tick per request, one result per tick.
//
//   channel  dir  handshake    payload
//   cmd_i    in   valid/ready  command, tx_byte, send_ack, sda_level
//   res_o    out  valid/ready  scl_level, sda_release, busy_res, done_res,
//                              rx_byte, ack_error
//   cfg_i    in   valid/ready  data (ack_timeout_limit), always ready
//
// One request per cycle sustained while results are taken; with an empty queue an
// accepted request is first written to the queue, and its result is then registered
// from the sequencer step into the result register.
// The sequencer advances one phase per request; its state loop sets the rate.
// Reset (rst_ni low, asynchronous) releases both lines, empties the queue and
// loads the timeout limit with 250.
// A stalled result holds the sequencer; the queue keeps taking requests until
// it is full.
// ----------------------------------------------------------------------------
module i2c_bit_level_master #(
  parameter int unsigned QueueDepth = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cm_cmd_if.sink   cmd_i,
  i2cm_res_if.source res_o,
  i2cm_cfg_if.sink   cfg_i
);
  import i2cm_pkg::*;

  q_status_t         q_status;
  q_entry_t          q_entry;
  logic              q_pop;
  logic [BYTE_W-1:0] limit_q;

  // timeout limit register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ACK_LIMIT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      limit_q <= cfg_i.data;
    end
  end

  // request front and queue
  i2cm_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .q_status_o (q_status),
    .q_pop_i    (q_pop),
    .q_entry_o  (q_entry)
  );

  // bus sequencer
  i2cm_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_pop_o    (q_pop),
    .q_entry_i  (q_entry),
    .limit_i    (limit_q),
    .res_o      (res_o)
  );

  // checks
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> !res_o.busy_res)
    else $error("done pulse while still busy");

  a_pop_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (!res_o.valid || res_o.ready))
    else $error("sequencer advanced over a pending result");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.ready |=> limit_q == $past(cfg_i.data))
    else $error("timeout limit not updated");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_status.valid)
    else $error("pop from empty queue");

endmodule
